// ----- src/stf_pkg.sv -----
// ---------------------------------------------------------------------------
// stf_pkg: shared types and constants for the trapezoid stepper follower
// Word layouts, register indexes, fixed-point constants and saturation.
// ---------------------------------------------------------------------------
package stf_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [15:0] IDLE_LIMIT = 16'd1000;

  localparam int CFG_W = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_CAP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_DIVISOR = 2'd2;

  localparam logic [31:0] ONE_STEP = 32'd1 << FRAC_BITS;
  localparam logic [63:0] SQ_MASK = ~((64'd1 << FRAC_BITS) - 64'd1);

  typedef struct packed {
    logic               func;
    logic signed [31:0] target_position;
  } in_word_t;

  typedef struct packed {
    logic step_pulse;
    logic dir_forward;
    logic motor_awake;
  } out_word_t;

  // clamp a 33-bit signed sum into the signed 32-bit range
  function automatic logic [31:0] sat33(input logic [32:0] s);
    logic [31:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/stf_if.sv -----
// ---------------------------------------------------------------------------
// stf_if: valid/ready channels for the trapezoid stepper follower
// Input channel carries a command word, output channel a result word.
// ---------------------------------------------------------------------------
interface stf_in_if;
  logic             valid;
  logic             ready;
  stf_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stf_out_if;
  logic               valid;
  logic               ready;
  stf_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/stepper_trapezoid_follower.sv -----
// A set-target word passes from accept through the execute and finish states to the result.
// A tick that moves runs both multiplications, then the velocity and position steps;
// a tick that finds the follower asleep or puts it to sleep goes from execute to finish.
// The serial shift-add multiplier, used twice per moving tick, sets how long it runs.
// One word is in work at a time; a finished result waits in the output register.
// Reset (rst, synchronous) sets the config registers to 1 and clears the motion state.
// ---------------------------------------------------------------------------
// stepper_trapezoid_follower: trapezoidal profile follower for a stepper
// Sequencer around one shared multiplier; braking compares dist*div to v^2.
// ---------------------------------------------------------------------------
module stepper_trapezoid_follower (
  input  logic                                clk,
  input  logic                                rst,
  stf_in_if.sink                              in_ch,
  stf_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [stf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stf_pkg::CFG_W-1:0]           cfg_data
);
  import stf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_VEL  = 3'd4;
  localparam logic [2:0] ST_POS  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state;

  logic [CFG_W-1:0] accel_step;
  logic [CFG_W-1:0] velocity_cap;
  logic [CFG_W-1:0] decel_divisor;

  logic        moving_forward;
  logic [31:0] velocity;
  logic [31:0] planned_position;
  logic [31:0] motor_position;
  logic [31:0] goal_position;
  logic [15:0] idle_ticks;
  logic        asleep;

  logic        cur_func;
  logic [31:0] cur_target;
  logic        pulse;
  logic [63:0] sq;
  logic        brake_near;

  logic        out_valid;
  out_word_t   out_data;

  logic        mul_start;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic        mul_busy;
  logic [63:0] mul_product;

  logic        run_motion;
  logic [31:0] vel_mag;
  logic [31:0] diff;
  logic [31:0] togo;
  logic [32:0] vx, ax, capx, v_sum, v_dif;
  logic [31:0] velocity_next;
  logic [31:0] planned_next;
  logic        out_free;

  assign in_ch.ready  = (state == ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
  assign out_free     = !out_valid || out_ch.ready;

  // idle check outcome: motion runs if motor != goal or, awake, idle count <= limit
  assign run_motion = (motor_position != goal_position) ||
                      (!asleep && !(idle_ticks > IDLE_LIMIT));

  assign vel_mag = velocity[31] ? (32'd0 - velocity) : velocity;
  assign diff    = goal_position - planned_position;
  assign togo    = diff[31] ? (32'd0 - diff) : diff;

  assign mul_start = (state == ST_EXEC && !cur_func && run_motion) ||
                     (state == ST_MUL1 && !mul_busy);
  assign mul_a = (state == ST_MUL1) ? {1'b0, decel_divisor} : vel_mag;
  assign mul_b = (state == ST_MUL1) ? togo : vel_mag;

  stf_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .busy    (mul_busy),
    .product (mul_product)
  );

  assign vx    = {velocity[31], velocity};
  assign ax    = {2'b00, accel_step};
  assign capx  = {2'b00, velocity_cap};
  assign v_sum = vx + ax;
  assign v_dif = vx - ax;

  always_comb begin
    velocity_next = velocity;
    if (moving_forward) begin
      if ($signed(goal_position) < $signed(planned_position) || brake_near) begin
        velocity_next = sat33(v_dif);
      end else if ($signed(planned_position) < $signed(goal_position)) begin
        velocity_next = ($signed(v_sum) < $signed(capx)) ? sat33(v_sum) : capx[31:0];
      end
    end else begin
      if ($signed(planned_position) < $signed(goal_position) || brake_near) begin
        velocity_next = sat33(v_sum);
      end else if ($signed(goal_position) < $signed(planned_position)) begin
        velocity_next = ($signed(v_dif) > $signed(33'd0 - capx)) ? sat33(v_dif)
                                                                 : 32'd0 - capx[31:0];
      end
    end
  end

  assign planned_next = planned_position + velocity;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_step    <= CFG_W'(1);
      velocity_cap  <= CFG_W'(1);
      decel_divisor <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL_STEP:    accel_step    <= cfg_data;
        REG_VELOCITY_CAP:  velocity_cap  <= cfg_data;
        REG_DECEL_DIVISOR: decel_divisor <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      moving_forward   <= 1'b1;
      velocity         <= '0;
      planned_position <= '0;
      motor_position   <= '0;
      goal_position    <= '0;
      idle_ticks       <= '0;
      asleep           <= 1'b0;
      pulse            <= 1'b0;
    end else begin
      // in ST_FIN the register is reloaded below instead
      if (out_valid && out_ch.ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            cur_func   <= in_ch.data.func;
            cur_target <= in_ch.data.target_position;
            pulse      <= 1'b0;
            state      <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cur_func) begin
            if (cur_target != goal_position) begin
              asleep     <= 1'b0;
              idle_ticks <= '0;
            end
            goal_position <= cur_target;
            state         <= ST_FIN;
          end else if (motor_position != goal_position) begin
            idle_ticks <= '0;
            state      <= ST_MUL1;
          end else if (asleep) begin
            state <= ST_FIN;
          end else if (idle_ticks > IDLE_LIMIT) begin
            asleep     <= 1'b1;
            idle_ticks <= '0;
            state      <= ST_FIN;
          end else begin
            idle_ticks <= idle_ticks + 16'd1;
            state      <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          // v^2 done; drop the fraction bits and start distance * divisor
          if (!mul_busy) begin
            sq    <= mul_product & SQ_MASK;
            state <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          if (!mul_busy) begin
            brake_near <= (mul_product <= sq);
            state      <= ST_VEL;
          end
        end
        ST_VEL: begin
          velocity <= velocity_next;
          state    <= ST_POS;
        end
        ST_POS: begin
          planned_position <= planned_next;
          if (moving_forward) begin
            if ($signed(motor_position) < $signed(planned_next) &&
                motor_position != goal_position) begin
              motor_position <= motor_position + ONE_STEP;
              pulse          <= 1'b1;
            end
            if (velocity[31]) begin
              moving_forward <= 1'b0;
            end
          end else begin
            if ($signed(planned_next) < $signed(motor_position) &&
                motor_position != goal_position) begin
              motor_position <= motor_position - ONE_STEP;
              pulse          <= 1'b1;
            end
            if (!velocity[31] && velocity != '0) begin
              moving_forward <= 1'b1;
            end
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.step_pulse  <= pulse;
            out_data.dir_forward <= moving_forward;
            out_data.motor_awake <= !asleep;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_FIN) |-> !mul_busy)
    else $error("multiplier busy outside a motion tick");

  a_target_no_pulse: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && cur_func) |-> !pulse)
    else $error("step pulse on a set-target word");

  a_motor_only_in_pos: assert property (@(posedge clk)
    (!rst && state != ST_POS) |=> (rst || motor_position == $past(motor_position)))
    else $error("motor position moved outside the position step");

  a_velocity_only_in_vel: assert property (@(posedge clk)
    (!rst && state != ST_VEL) |=> (rst || velocity == $past(velocity)))
    else $error("velocity changed outside the velocity step");

endmodule

// ----- src/stf_mul.sv -----
// ---------------------------------------------------------------------------
// stf_mul: shift-add multiplier, 32 x 32 -> 64
// One multiplier bit per cycle; finishes once the remaining multiplier is zero.
// ---------------------------------------------------------------------------
module stf_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic        busy,
  output logic [63:0] product
);

  logic [63:0] mcand;
  logic [31:0] mplier;
  logic [63:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      mplier <= '0;
    end else if (start) begin
      mplier <= op_b;
      mcand  <= {32'd0, op_a};
      acc    <= '0;
    end else if (mplier != '0) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign busy    = (mplier != '0);
  assign product = acc;

endmodule
